// ===== hdl/dha_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dha_pkg: shared types and constants of the hysteresis alarm core
// Level codes, per-metric rule fields, state entry layout, register indexes.
// ----------------------------------------------------------------------------
package dha_pkg;

  localparam int NumMetricsDef = 6;
  localparam int ValueBitsDef  = 13;

  // configuration register map
  localparam int NumBandRegs = 6;   // bands_m0 .. bands_m5
  localparam int CfgIdxRules = 6;   // rule_flags
  localparam int CfgIdxW     = 3;
  localparam int RuleFlagsW  = 48;
  localparam int RuleByteW   = 8;
  localparam logic [RuleByteW-1:0] RuleByteMask = 8'd255;

  localparam int CountW = 4;
  localparam logic [CountW-1:0] CountMax = 4'd15;

  typedef enum logic [1:0] {
    LvlNone = 2'd0,
    LvlWarn = 2'd1,
    LvlCrit = 2'd2
  } dha_level_e;

  // one rule byte: invert in bit 0, confirm depth in 4:1, root in 7:5
  typedef struct packed {
    logic [2:0]        root;
    logic [CountW-1:0] depth;
    logic              invert;
  } dha_rule_t;

  // one state memory entry per metric
  typedef struct packed {
    logic              dep;
    dha_level_e        level;
    dha_level_e        pend;
    logic [CountW-1:0] cnt;
  } dha_entry_t;

endpackage

// ===== hdl/dha_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dha_if: request channels of the hysteresis alarm core
// Sample request in, result request out; valid/ready handshake.
// ----------------------------------------------------------------------------
interface dha_sample_if #(
  parameter int VALUE_BITS = dha_pkg::ValueBitsDef
);
  logic                  valid;
  logic                  ready;
  logic [2:0]            metric;
  logic                  sample_ok;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, metric, sample_ok, value, input ready);
  modport sink   (input valid, metric, sample_ok, value, output ready);
endinterface

interface dha_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  level;
  logic        event_res;
  logic [1:0]  prev_level;
  logic        dependent;
  logic [1:0]  severity;
  logic [31:0] event_total;

  modport source (output valid, level, event_res, prev_level, dependent, severity,
                  event_total, input ready);
  modport sink   (input valid, level, event_res, prev_level, dependent, severity,
                  event_total, output ready);
endinterface

// ===== hdl/dha_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dha_cfg_regs: threshold and rule registers
// Holds the band and rule registers, selects the set for one metric.
// ----------------------------------------------------------------------------
module dha_cfg_regs #(
  parameter int VALUE_BITS = dha_pkg::ValueBitsDef,
  parameter int CFG_DATA_W = 4 * VALUE_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [dha_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i,
  input  logic [2:0]                   sel_metric_i,
  output logic [4*VALUE_BITS-1:0]      bands_o,
  output dha_pkg::dha_rule_t           rule_o
);

  localparam int BandW = 4 * VALUE_BITS;

  logic [BandW-1:0]               bands_q [dha_pkg::NumBandRegs];
  logic [dha_pkg::RuleFlagsW-1:0] rules_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < dha_pkg::NumBandRegs; i++) begin
        bands_q[i] <= '0;
      end
      rules_q <= '0;
    end else if (cfg_we_i) begin
      for (int i = 0; i < dha_pkg::NumBandRegs; i++) begin
        if (cfg_idx_i == dha_pkg::CfgIdxW'(i)) begin
          bands_q[i] <= cfg_data_i[BandW-1:0];
        end
      end
      if (cfg_idx_i == dha_pkg::CfgIdxW'(dha_pkg::CfgIdxRules)) begin
        rules_q <= cfg_data_i[dha_pkg::RuleFlagsW-1:0];
      end
    end
  end

  // metrics without a register read as all zero
  always_comb begin
    logic [dha_pkg::RuleByteW-1:0] rb;
    bands_o = '0;
    rb      = '0;
    for (int i = 0; i < dha_pkg::NumBandRegs; i++) begin
      if (sel_metric_i == 3'(i)) begin
        bands_o = bands_q[i];
        rb      = rules_q[dha_pkg::RuleByteW*i +: dha_pkg::RuleByteW] & dha_pkg::RuleByteMask;
      end
    end
    rule_o = dha_pkg::dha_rule_t'(rb);
  end

endmodule

// ===== hdl/dha_state_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dha_state_mem: per-metric alarm state memory
// One write port, two registered read ports; unwritten entries read as zero.
// ----------------------------------------------------------------------------
module dha_state_mem #(
  parameter int NUM_METRICS = dha_pkg::NumMetricsDef,
  parameter int AW          = (NUM_METRICS > 1) ? $clog2(NUM_METRICS) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rd_en_i,
  input  logic [AW-1:0]       rd_addr_a_i,
  input  logic [AW-1:0]       rd_addr_b_i,
  output dha_pkg::dha_entry_t rd_entry_a_o,
  output dha_pkg::dha_level_e rd_level_b_o,
  input  logic                wr_en_i,
  input  logic [AW-1:0]       wr_addr_i,
  input  dha_pkg::dha_entry_t wr_entry_i
);

  dha_pkg::dha_entry_t mem [NUM_METRICS];
  logic [NUM_METRICS-1:0] written_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else if (wr_en_i) begin
      written_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_entry_a_o <= written_q[rd_addr_a_i] ? mem[rd_addr_a_i] : '0;
      rd_level_b_o <= written_q[rd_addr_b_i] ? mem[rd_addr_b_i].level : dha_pkg::LvlNone;
    end
  end

endmodule

// ===== hdl/dha_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dha_update: hysteresis classify and debounce step
// Computes one metric's next state entry from its current entry and a sample.
// ----------------------------------------------------------------------------
module dha_update #(
  parameter int VALUE_BITS = dha_pkg::ValueBitsDef
) (
  input  logic                    ok_i,
  input  logic [VALUE_BITS-1:0]   value_i,
  input  logic [4*VALUE_BITS-1:0] bands_i,
  input  dha_pkg::dha_rule_t      rule_i,
  input  dha_pkg::dha_entry_t     cur_i,
  input  dha_pkg::dha_level_e     root_level_i,
  input  logic                    root_in_i,
  input  logic                    root_self_i,
  output dha_pkg::dha_entry_t     entry_o,
  output logic                    event_o,
  output dha_pkg::dha_level_e     from_o
);

  logic [VALUE_BITS-1:0] warn_on, warn_clr, crit_on, crit_clr;
  dha_pkg::dha_level_e   cand;
  logic [dha_pkg::CountW-1:0] cnt_inc;

  assign warn_on  = bands_i[0*VALUE_BITS +: VALUE_BITS];
  assign warn_clr = bands_i[1*VALUE_BITS +: VALUE_BITS];
  assign crit_on  = bands_i[2*VALUE_BITS +: VALUE_BITS];
  assign crit_clr = bands_i[3*VALUE_BITS +: VALUE_BITS];

  // candidate level; inverted sense means lower is worse
  always_comb begin
    cand = dha_pkg::LvlNone;
    if (rule_i.invert) begin
      unique case (cur_i.level)
        dha_pkg::LvlCrit: cand = (value_i > crit_clr) ? dha_pkg::LvlWarn : dha_pkg::LvlCrit;
        dha_pkg::LvlWarn: begin
          if (value_i <= crit_on)      cand = dha_pkg::LvlCrit;
          else if (value_i > warn_clr) cand = dha_pkg::LvlNone;
          else                         cand = dha_pkg::LvlWarn;
        end
        default: begin
          if (value_i <= crit_on)      cand = dha_pkg::LvlCrit;
          else if (value_i <= warn_on) cand = dha_pkg::LvlWarn;
          else                         cand = dha_pkg::LvlNone;
        end
      endcase
    end else begin
      unique case (cur_i.level)
        dha_pkg::LvlCrit: cand = (value_i < crit_clr) ? dha_pkg::LvlWarn : dha_pkg::LvlCrit;
        dha_pkg::LvlWarn: begin
          if (value_i >= crit_on)      cand = dha_pkg::LvlCrit;
          else if (value_i < warn_clr) cand = dha_pkg::LvlNone;
          else                         cand = dha_pkg::LvlWarn;
        end
        default: begin
          if (value_i >= crit_on)      cand = dha_pkg::LvlCrit;
          else if (value_i >= warn_on) cand = dha_pkg::LvlWarn;
          else                         cand = dha_pkg::LvlNone;
        end
      endcase
    end
  end

  assign cnt_inc = (cur_i.cnt < dha_pkg::CountMax) ? cur_i.cnt + 1'b1 : cur_i.cnt;

  // a differing pending level always carries a count of at least one,
  // so depths of zero and one confirm on the second sample
  always_comb begin
    entry_o = cur_i;
    event_o = 1'b0;
    from_o  = dha_pkg::LvlNone;
    priority if (!ok_i) begin
      entry_o.level = dha_pkg::LvlNone;
      entry_o.pend  = dha_pkg::LvlNone;
      entry_o.cnt   = '0;
    end else if (cand == cur_i.level) begin
      entry_o.pend = cur_i.level;
      entry_o.cnt  = '0;
    end else if (cand != cur_i.pend) begin
      entry_o.pend = cand;
      entry_o.cnt  = dha_pkg::CountW'(1);
    end else if (cnt_inc >= rule_i.depth) begin
      event_o       = 1'b1;
      from_o        = cur_i.level;
      entry_o.level = cand;
      entry_o.cnt   = '0;
      entry_o.dep   = root_in_i && (cand != dha_pkg::LvlNone) &&
                      (root_self_i || (root_level_i != dha_pkg::LvlNone));
    end else begin
      entry_o.cnt = cnt_inc;
    end
  end

endmodule

// ===== hdl/debounced_hysteresis_alarm_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// debounced_hysteresis_alarm_core: multi-level hysteresis alarm with debounce
// Per-metric state in a small two-read-port memory; read-modify-write pipe.
// ----------------------------------------------------------------------------
// Pipeline: an accepted sample is registered in stage 1, its result in the output register.
// Throughput: one sample per cycle unless the result output stalls; the state memory read in
//   the accept cycle and the previous sample's stage 1 write-back are bridged by a one-entry bypass.
// Reset: control, counters and config clear at once; the state memory keeps
//   one written bit per entry, so unwritten entries read as none, no sweep.
// ----------------------------------------------------------------------------
module debounced_hysteresis_alarm_core #(
  parameter int NUM_METRICS = dha_pkg::NumMetricsDef,
  parameter int VALUE_BITS  = dha_pkg::ValueBitsDef,
  localparam int CfgDataW   = (4 * VALUE_BITS > dha_pkg::RuleFlagsW) ?
                              4 * VALUE_BITS : dha_pkg::RuleFlagsW
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [dha_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgDataW-1:0]         cfg_data_i,
  dha_sample_if.sink                  sample_i,
  dha_result_if.source                result_o
);

  localparam int AW    = (NUM_METRICS > 1) ? $clog2(NUM_METRICS) : 1;
  localparam int CntW  = $clog2(NUM_METRICS + 1);
  localparam int BandW = 4 * VALUE_BITS;

  // --------------------------------------------------------------------------
  // Stage 0: accept, select the metric's rule and bands, issue memory reads
  // (own entry on port A, root metric's level on port B).
  // --------------------------------------------------------------------------
  logic               accept;
  logic [BandW-1:0]   sel_bands;
  dha_pkg::dha_rule_t sel_rule;

  dha_cfg_regs #(
    .VALUE_BITS (VALUE_BITS),
    .CFG_DATA_W (CfgDataW)
  ) u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .sel_metric_i (sample_i.metric),
    .bands_o      (sel_bands),
    .rule_o       (sel_rule)
  );

  // Stage 1 registers
  logic                  s1_valid_q;
  logic [2:0]            s1_metric_q;
  logic                  s1_ok_q;
  logic [VALUE_BITS-1:0] s1_value_q;
  logic [BandW-1:0]      s1_bands_q;
  dha_pkg::dha_rule_t    s1_rule_q;
  logic                  s1_adv;

  // Output register
  logic                out_valid_q;
  dha_pkg::dha_level_e out_level_q, out_from_q, out_sev_q;
  logic                out_event_q, out_dep_q;
  logic [31:0]         out_total_q;

  assign s1_adv         = s1_valid_q && (!out_valid_q || result_o.ready);
  assign sample_i.ready = !s1_valid_q || s1_adv;
  assign accept         = sample_i.valid && sample_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_metric_q <= sample_i.metric;
      s1_ok_q     <= sample_i.sample_ok;
      s1_value_q  <= sample_i.value;
      s1_bands_q  <= sel_bands;
      s1_rule_q   <= sel_rule;
    end
  end

  // --------------------------------------------------------------------------
  // State memory and write-back bypass. The bypass holds the latest write,
  // which always matches the memory's newest content for that entry, so it
  // covers the read that races the previous sample's write-back.
  // --------------------------------------------------------------------------
  dha_pkg::dha_entry_t mem_entry, cur_entry, upd_entry;
  dha_pkg::dha_level_e mem_root_level, root_level;
  logic                wr_en;
  logic [AW-1:0]       s1_addr, root_addr;

  logic                byp_valid_q;
  logic [AW-1:0]       byp_addr_q;
  dha_pkg::dha_entry_t byp_entry_q;

  dha_state_mem #(
    .NUM_METRICS (NUM_METRICS),
    .AW          (AW)
  ) u_mem (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rd_en_i      (accept),
    .rd_addr_a_i  (sample_i.metric[AW-1:0]),
    .rd_addr_b_i  (sel_rule.root[AW-1:0]),
    .rd_entry_a_o (mem_entry),
    .rd_level_b_o (mem_root_level),
    .wr_en_i      (wr_en),
    .wr_addr_i    (s1_addr),
    .wr_entry_i   (upd_entry)
  );

  assign s1_addr   = s1_metric_q[AW-1:0];
  assign root_addr = s1_rule_q.root[AW-1:0];

  assign cur_entry  = (byp_valid_q && byp_addr_q == s1_addr) ? byp_entry_q : mem_entry;
  assign root_level = (byp_valid_q && byp_addr_q == root_addr) ? byp_entry_q.level
                                                               : mem_root_level;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_valid_q <= 1'b0;
    end else if (wr_en) begin
      byp_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      byp_addr_q  <= s1_addr;
      byp_entry_q <= upd_entry;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: classify, debounce, commit. A root equal to the metric itself
  // sees the freshly committed level.
  // --------------------------------------------------------------------------
  logic                s1_in_range, root_in, root_self, upd_event;
  dha_pkg::dha_level_e upd_from;

  assign s1_in_range = int'(s1_metric_q) < NUM_METRICS;
  assign root_in     = int'(s1_rule_q.root) < NUM_METRICS;
  assign root_self   = s1_rule_q.root == s1_metric_q;
  assign wr_en       = s1_adv && s1_in_range;

  dha_update #(
    .VALUE_BITS (VALUE_BITS)
  ) u_upd (
    .ok_i         (s1_ok_q),
    .value_i      (s1_value_q),
    .bands_i      (s1_bands_q),
    .rule_i       (s1_rule_q),
    .cur_i        (cur_entry),
    .root_level_i (root_level),
    .root_in_i    (root_in),
    .root_self_i  (root_self),
    .entry_o      (upd_entry),
    .event_o      (upd_event),
    .from_o       (upd_from)
  );

  // --------------------------------------------------------------------------
  // Severity: count of non-dependent metrics at warning and at critical,
  // adjusted by the old and new contribution of the metric being written.
  // --------------------------------------------------------------------------
  logic [CntW-1:0]     cnt_warn_q, cnt_warn_d, cnt_crit_q, cnt_crit_d;
  logic [31:0]         total_q, total_d;
  logic                old_w, old_c, new_w, new_c;
  dha_pkg::dha_level_e sev_d;

  assign old_w = !cur_entry.dep && cur_entry.level == dha_pkg::LvlWarn;
  assign old_c = !cur_entry.dep && cur_entry.level == dha_pkg::LvlCrit;
  assign new_w = !upd_entry.dep && upd_entry.level == dha_pkg::LvlWarn;
  assign new_c = !upd_entry.dep && upd_entry.level == dha_pkg::LvlCrit;

  always_comb begin
    cnt_warn_d = cnt_warn_q;
    cnt_crit_d = cnt_crit_q;
    total_d    = total_q;
    if (s1_in_range) begin
      cnt_warn_d = cnt_warn_q + CntW'(new_w) - CntW'(old_w);
      cnt_crit_d = cnt_crit_q + CntW'(new_c) - CntW'(old_c);
      total_d    = total_q + 32'(upd_event);
    end
    priority if (cnt_crit_d != '0) sev_d = dha_pkg::LvlCrit;
    else if (cnt_warn_d != '0)     sev_d = dha_pkg::LvlWarn;
    else                           sev_d = dha_pkg::LvlNone;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_warn_q <= '0;
      cnt_crit_q <= '0;
      total_q    <= '0;
    end else if (s1_adv) begin
      cnt_warn_q <= cnt_warn_d;
      cnt_crit_q <= cnt_crit_d;
      total_q    <= total_d;
    end
  end

  // --------------------------------------------------------------------------
  // Output register; out-of-range metrics report zeros plus the totals.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_level_q <= s1_in_range ? upd_entry.level : dha_pkg::LvlNone;
      out_event_q <= s1_in_range && upd_event;
      out_from_q  <= s1_in_range ? upd_from : dha_pkg::LvlNone;
      out_dep_q   <= s1_in_range && upd_entry.dep;
      out_sev_q   <= sev_d;
      out_total_q <= total_d;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.level       = out_level_q;
  assign result_o.event_res   = out_event_q;
  assign result_o.prev_level  = out_from_q;
  assign result_o.dependent   = out_dep_q;
  assign result_o.severity    = out_sev_q;
  assign result_o.event_total = out_total_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cnt_warn_q) + int'(cnt_crit_q) <= NUM_METRICS)
    else $error("severity counts exceed metric count");

  a_total_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en && upd_event |=> total_q == $past(total_q) + 32'd1)
    else $error("transition total did not advance on an event");

  a_event_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en && upd_event |-> upd_entry.level != cur_entry.level)
    else $error("event without a level change");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_metric_q))
    else $error("stalled stage 1 sample lost");

endmodule
